// ===== hdl/pulse_period_differential_bit_decoder_unit_defines.svh =====
// Assertion macros for the bound checker in hdl/ppdbd_checker.sv.
`ifndef PULSE_PERIOD_DIFFERENTIAL_BIT_DECODER_UNIT_DEFINES_SVH
`define PULSE_PERIOD_DIFFERENTIAL_BIT_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define PPDBD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ppdbd: implication check failed");

// Next-cycle implication, sampled on i_clk, off while in reset.
`define PPDBD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ppdbd: next-cycle check failed");

`endif

// ===== hdl/ppdbd_pkg.sv =====
package ppdbd_pkg;

    // period codes
    typedef logic [2:0] t_code;
    localparam t_code CODE_NONE  = 3'd0;
    localparam t_code CODE_ONE   = 3'd1;
    localparam t_code CODE_TWO   = 3'd2;
    localparam t_code CODE_THREE = 3'd3;
    localparam t_code CODE_STOP  = 3'd4;
    localparam t_code CODE_START = 3'd5;

    // result events
    typedef logic [1:0] t_event;
    localparam t_event EV_BIT   = 2'd0;
    localparam t_event EV_STOP  = 2'd1;
    localparam t_event EV_ABORT = 2'd2;
    localparam t_event EV_CUT   = 2'd3;

    // register indexes (byte address / 4)
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_STEP     = 2'd0;
    localparam t_reg_idx REG_SHORTEST = 2'd1;
    localparam t_reg_idx REG_LONGEST  = 2'd2;

    localparam logic [15:0] STEP_RESET     = 16'd3125;
    localparam logic [15:0] SHORTEST_RESET = 16'd3125;
    localparam logic [15:0] LONGEST_RESET  = 16'd15625;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef struct packed {
        logic [15:0] step_us;
        logic [15:0] shortest_code_us;
        logic [15:0] longest_code_us;
    } t_cfg;

    // classified word passed from front to back
    typedef struct packed {
        t_code code;
        logic  capture_end;
    } t_sym;

    typedef struct packed {
        t_event     event_res;
        logic       bit_value;
        logic [7:0] frame_length;
        logic       last_result;
    } t_result;

endpackage

// ===== hdl/ppdbd_queue.sv =====
module ppdbd_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ppdbd_pkg::t_sym i_sym,
    output logic            o_full,
    input  logic            i_pop,
    output ppdbd_pkg::t_sym o_sym,
    output logic            o_empty
);
    import ppdbd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_sym          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;
    logic          wr, rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_sym   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_sym;
        end
    end

endmodule

// ===== hdl/ppdbd_front.sv =====
module ppdbd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ppdbd_pkg::t_cfg i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [15:0]     i_period_us,
    input  logic            i_capture_end,
    output logic            o_push,
    output ppdbd_pkg::t_sym o_sym,
    input  logic            i_full
);
    import ppdbd_pkg::*;

    // restoring divide of a 17-bit dividend, one quotient bit a cycle
    localparam int DIV_STEPS = 17;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PUSH
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_rem;
    logic [16:0]      r_dvd;
    logic             r_reject;
    logic             r_cap;

    logic [15:0] half;
    logic [16:0] sum;
    logic [16:0] upper;
    logic        reject;
    logic [16:0] shifted;
    logic [16:0] diff;
    logic        ge;
    logic        accept;

    assign half    = {1'b0, i_cfg.step_us[15:1]};
    assign sum     = {1'b0, i_period_us} + {1'b0, half};
    assign upper   = {1'b0, i_cfg.longest_code_us} + {1'b0, half};
    assign reject  = (i_cfg.step_us == 16'd0)
                  || (sum < {1'b0, i_cfg.shortest_code_us})
                  || ({1'b0, i_period_us} > upper);

    assign shifted = {r_rem, r_dvd[16]};
    assign ge      = (shifted >= {1'b0, i_cfg.step_us});
    assign diff    = shifted - {1'b0, i_cfg.step_us};

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = (r_state == S_PUSH);

    // quotient now sits in r_dvd
    always_comb begin
        o_sym.capture_end = r_cap;
        if (!r_reject && (r_dvd != 17'd0) && (r_dvd <= 17'(CODE_START))) begin
            o_sym.code = r_dvd[2:0];
        end else begin
            o_sym.code = CODE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_DIV;
                        r_cnt   <= CNT_W'(DIV_STEPS - 1);
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rem    <= '0;
            r_dvd    <= sum;
            r_reject <= reject;
            r_cap    <= i_capture_end;
        end else if (r_state == S_DIV) begin
            r_rem <= ge ? diff[15:0] : shifted[15:0];
            r_dvd <= {r_dvd[15:0], ge};
        end
    end

endmodule

// ===== hdl/ppdbd_back.sv =====
module ppdbd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppdbd_pkg::t_sym    i_sym,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ppdbd_pkg::t_result o_result
);
    import ppdbd_pkg::*;

    logic       r_in_frame;
    logic       r_prev_bit;
    logic [7:0] r_bit_count;
    logic       r_out_valid;
    t_result    r_out;
    logic       r_pend_valid;
    t_result    r_pend;

    logic       fst_v;
    t_result    fst;
    logic       a_nf, a_pb;
    logic [7:0] a_cnt;
    logic       cut_v;
    t_result    cut;
    logic       good;
    logic       bit_v;
    logic       out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_pop       = !i_empty && !r_pend_valid && out_free;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        fst_v = 1'b0;
        fst   = '0;
        a_nf  = r_in_frame;
        a_pb  = r_prev_bit;
        a_cnt = r_bit_count;
        good  = 1'b0;
        bit_v = 1'b0;

        // differential bit against the previous one
        if (r_prev_bit) begin
            good  = (i_sym.code == CODE_ONE) || (i_sym.code == CODE_TWO);
            bit_v = (i_sym.code == CODE_TWO);
        end else begin
            good  = (i_sym.code == CODE_TWO) || (i_sym.code == CODE_THREE);
            bit_v = (i_sym.code == CODE_THREE);
        end

        if (i_sym.code == CODE_START) begin
            fst_v              = r_in_frame && (r_bit_count != 8'd0);
            fst.event_res      = EV_CUT;
            fst.frame_length   = r_bit_count;
            a_nf               = 1'b1;
            a_pb               = 1'b1;
            a_cnt              = 8'd0;
        end else if (r_in_frame) begin
            fst_v = 1'b1;
            if (i_sym.code == CODE_STOP) begin
                fst.event_res    = EV_STOP;
                fst.frame_length = r_bit_count;
                a_nf             = 1'b0;
                a_cnt            = 8'd0;
            end else if (!good) begin
                fst.event_res    = EV_ABORT;
                fst.frame_length = r_bit_count;
                a_nf             = 1'b0;
                a_cnt            = 8'd0;
            end else begin
                a_cnt            = (r_bit_count == COUNT_MAX) ? COUNT_MAX
                                                              : r_bit_count + 8'd1;
                a_pb             = bit_v;
                fst.event_res    = EV_BIT;
                fst.bit_value    = bit_v;
                fst.frame_length = a_cnt;
            end
        end

        // capture end closes a non-empty open frame
        cut_v              = i_sym.capture_end && a_nf && (a_cnt != 8'd0);
        cut                = '0;
        cut.event_res      = EV_CUT;
        cut.frame_length   = a_cnt;
        cut.last_result    = 1'b1;
        fst.last_result    = !cut_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_prev_bit   <= 1'b1;
            r_bit_count  <= 8'd0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_sym.capture_end) begin
                    r_in_frame  <= 1'b0;
                    r_prev_bit  <= 1'b1;
                    r_bit_count <= 8'd0;
                end else begin
                    r_in_frame  <= a_nf;
                    r_prev_bit  <= a_pb;
                    r_bit_count <= a_cnt;
                end
            end
            if (out_free) begin
                if (r_pend_valid) begin
                    r_out        <= r_pend;
                    r_out_valid  <= 1'b1;
                    r_pend_valid <= 1'b0;
                end else if (o_pop && (fst_v || cut_v)) begin
                    r_out        <= fst_v ? fst : cut;
                    r_out_valid  <= 1'b1;
                    r_pend       <= cut;
                    r_pend_valid <= fst_v && cut_v;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== hdl/pulse_period_differential_bit_decoder_unit.sv =====
// Path: an accepted word passes the front's 17-step serial divider, the queue, the back
// and its output register. The front takes no new word until the last one is pushed.
// A second result (capture-end cut) follows in the cycle after the first is taken.
// Reset (i_rst_n low, synchronous): registers return to 3125/3125/15625, no frame open,
// previous bit 1, count 0, queue and output stage empty. No clearing pass.
module pulse_period_differential_bit_decoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_period_us,
    input  logic        i_capture_end,
    // result words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_res,
    output logic        o_bit_value,
    output logic [7:0]  o_frame_length,
    output logic        o_last_result
);
    import ppdbd_pkg::*;

    // Configuration registers live here. The user must change them only while the block is
    // idle; the block does not enforce it. The front reads them directly, no shadow copy.
    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    t_sym     push_sym;
    logic     push;
    logic     full;
    t_sym     head_sym;
    logic     empty;
    logic     pop;
    t_result  result;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_us          <= STEP_RESET;
            r_cfg.shortest_code_us <= SHORTEST_RESET;
            r_cfg.longest_code_us  <= LONGEST_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_STEP:     r_cfg.step_us          <= pwdata[15:0];
                REG_SHORTEST: r_cfg.shortest_code_us <= pwdata[15:0];
                REG_LONGEST:  r_cfg.longest_code_us  <= pwdata[15:0];
                default: ;    // beyond the register list: ignored
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STEP:     prdata = {16'd0, r_cfg.step_us};
            REG_SHORTEST: prdata = {16'd0, r_cfg.shortest_code_us};
            REG_LONGEST:  prdata = {16'd0, r_cfg.longest_code_us};
            default:      prdata = 32'd0;
        endcase
    end

    // Front: window check at acceptance, then round-to-nearest divide.
    ppdbd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_period_us   (i_period_us),
        .i_capture_end (i_capture_end),
        .o_push        (push),
        .o_sym         (push_sym),
        .i_full        (full)
    );

    // Short queue of classified codes so either side may stall alone.
    ppdbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_sym   (push_sym),
        .o_full  (full),
        .i_pop   (pop),
        .o_sym   (head_sym),
        .o_empty (empty)
    );

    // Back: frame state machine, output register plus one pending slot
    // for the capture-end cut that may follow a data bit.
    ppdbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sym       (head_sym),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_event_res    = result.event_res;
    assign o_bit_value    = result.bit_value;
    assign o_frame_length = result.frame_length;
    assign o_last_result  = result.last_result;

endmodule

// ===== hdl/ppdbd_checker.sv =====
`include "pulse_period_differential_bit_decoder_unit_defines.svh"

module ppdbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_event_res,
    input logic        o_bit_value,
    input logic [7:0]  o_frame_length,
    input logic        o_last_result
);
    import ppdbd_pkg::*;

    // stalled result word holds
    `PPDBD_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable({o_event_res, o_bit_value, o_frame_length, o_last_result}))

    // a data bit always counts itself
    `PPDBD_ASSERT_IMP(a_bit_len, o_out_valid && (o_event_res == EV_BIT), o_frame_length != 8'd0)

    // a cut is only ever reported for a non-empty frame
    `PPDBD_ASSERT_IMP(a_cut_len, o_out_valid && (o_event_res == EV_CUT), o_frame_length != 8'd0)

    // bit value is zero on every frame event
    `PPDBD_ASSERT_IMP(a_evt_bit, o_out_valid && (o_event_res != EV_BIT), !o_bit_value)

endmodule

bind pulse_period_differential_bit_decoder_unit ppdbd_checker u_ppdbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_event_res    (o_event_res),
    .o_bit_value    (o_bit_value),
    .o_frame_length (o_frame_length),
    .o_last_result  (o_last_result)
);

// ===== tb/ppdbd_checker.sv =====
`timescale 1ns / 1ps

// Watches the config port and both word channels, predicts the decoded
// results and checks every output word against them in order.
module ppdbd_tb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_period_us,
    input  logic        i_capture_end,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_event_res,
    input  logic        i_bit_value,
    input  logic [7:0]  i_frame_length,
    input  logic        i_last_result,
    output int          o_fail_count,
    output int          o_pending
);
    import ppdbd_pkg::*;

    // shadow registers
    logic [15:0] step_cfg;
    logic [15:0] shortest_cfg;
    logic [15:0] longest_cfg;

    // shadow decoder state
    logic       frm_open;
    logic       prev_bit;
    logic [7:0] bit_cnt;

    t_result decoded_q[$];

    function automatic t_code classify_period(logic [15:0] period);
        int unsigned p;
        int unsigned step;
        int unsigned half;
        int unsigned nearest;
        p    = period;
        step = step_cfg;
        half = step >> 1;
        if (step == 0) return CODE_NONE;
        if (p + half < int'(shortest_cfg)) return CODE_NONE;
        if (p > int'(longest_cfg) + half) return CODE_NONE;
        nearest = (p + half) / step;
        if (nearest < CODE_ONE || nearest > CODE_START) return CODE_NONE;
        return t_code'(nearest);
    endfunction

    function automatic t_result make_result(t_event ev, logic b, logic [7:0] len);
        t_result r;
        r.event_res    = ev;
        r.bit_value    = b;
        r.frame_length = len;
        r.last_result  = 1'b0;
        return r;
    endfunction

    task automatic decode_period(logic [15:0] period, logic cap_end);
        t_result r[2];
        int      n;
        t_code   code;
        logic    ok;
        logic    b;
        n    = 0;
        ok   = 1'b0;
        b    = 1'b0;
        code = classify_period(period);
        if (code == CODE_START) begin
            // new start cuts a frame only if it already holds bits
            if (frm_open && bit_cnt != 0) begin
                r[n] = make_result(EV_CUT, 1'b0, bit_cnt);
                n++;
            end
            frm_open = 1'b1;
            prev_bit = 1'b1;
            bit_cnt  = '0;
        end else if (frm_open) begin
            if (code == CODE_STOP) begin
                r[n] = make_result(EV_STOP, 1'b0, bit_cnt);
                n++;
                frm_open = 1'b0;
                bit_cnt  = '0;
            end else begin
                if (!prev_bit) begin
                    if (code == CODE_TWO) begin
                        ok = 1'b1; b = 1'b0;
                    end else if (code == CODE_THREE) begin
                        ok = 1'b1; b = 1'b1;
                    end
                end else begin
                    if (code == CODE_ONE) begin
                        ok = 1'b1; b = 1'b0;
                    end else if (code == CODE_TWO) begin
                        ok = 1'b1; b = 1'b1;
                    end
                end
                if (!ok) begin
                    r[n] = make_result(EV_ABORT, 1'b0, bit_cnt);
                    n++;
                    frm_open = 1'b0;
                    bit_cnt  = '0;
                end else begin
                    if (bit_cnt != COUNT_MAX) bit_cnt = bit_cnt + 8'd1;
                    prev_bit = b;
                    r[n] = make_result(EV_BIT, b, bit_cnt);
                    n++;
                end
            end
        end
        if (cap_end) begin
            if (frm_open && bit_cnt != 0) begin
                r[n] = make_result(EV_CUT, 1'b0, bit_cnt);
                n++;
            end
            frm_open = 1'b0;
            prev_bit = 1'b1;
            bit_cnt  = '0;
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) r[i].last_result = 1'b1;
            decoded_q.insert(decoded_q.size(), r[i]);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            step_cfg     = STEP_RESET;
            shortest_cfg = SHORTEST_RESET;
            longest_cfg  = LONGEST_RESET;
            frm_open     = 1'b0;
            prev_bit     = 1'b1;
            bit_cnt      = '0;
            decoded_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_STEP:     step_cfg     = i_pwdata[15:0];
                    REG_SHORTEST: shortest_cfg = i_pwdata[15:0];
                    REG_LONGEST:  longest_cfg  = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got.event_res    = i_event_res;
                got.bit_value    = i_bit_value;
                got.frame_length = i_frame_length;
                got.last_result  = i_last_result;
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result word: expected none, actual ev=%0d bit=%0d len=%0d last=%0d",
                             $time, got.event_res, got.bit_value, got.frame_length,
                             got.last_result);
                    o_fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    if (got != want) begin
                        $display("%0t: result mismatch: expected ev=%0d bit=%0d len=%0d last=%0d, actual ev=%0d bit=%0d len=%0d last=%0d",
                                 $time, want.event_res, want.bit_value, want.frame_length,
                                 want.last_result, got.event_res, got.bit_value,
                                 got.frame_length, got.last_result);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) decode_period(i_period_us, i_capture_end);
        end
        o_pending = decoded_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ppdbd_pkg::*;

    // run-length guards, all in clock cycles
    localparam int CYCLE_LIMIT     = 500000;
    localparam int DRAIN_CYCLES    = 60;   // comfortably past a word's trip through the block
    localparam int HOLD_OFF_CYCLES = 400;  // long receiver stall to back the block up

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [15:0] period_us   = '0;
    logic        capture_end = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  event_res;
    logic        bit_value;
    logic [7:0]  frame_length;
    logic        last_result;

    int fail_count;
    int pending;

    // stimulus controls
    bit idle_on      = 1'b1;   // random gaps on both channels
    bit hold_off_req = 1'b0;   // asks the receiver for one long stall
    int cur_step     = int'(STEP_RESET);
    int words_sent   = 0;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pulse_period_differential_bit_decoder_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_period_us    (period_us),
        .i_capture_end  (capture_end),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_event_res    (event_res),
        .o_bit_value    (bit_value),
        .o_frame_length (frame_length),
        .o_last_result  (last_result)
    );

    ppdbd_tb_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_period_us    (period_us),
        .i_capture_end  (capture_end),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_event_res    (event_res),
        .i_bit_value    (bit_value),
        .i_frame_length (frame_length),
        .i_last_result  (last_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Receiver side: ready is set on falling edges. Either the one long
    // hold-off, a short random burst of back-pressure, or ready.
    always begin
        @(negedge i_clk);
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            out_ready <= 1'b0;
            for (int c = 0; c < HOLD_OFF_CYCLES; c++) @(negedge i_clk);
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: a stuck handshake or a lost result ends the run here.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Offer one word and hold it until taken. Returns on the falling edge
    // after acceptance with valid still high, so back-to-back words never
    // see valid dropped and raised in the same step.
    task automatic send_word(logic [15:0] p, logic cap);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        in_valid    <= 1'b1;
        period_us   <= p;
        capture_end <= cap;
        do @(posedge i_clk); while (!(in_valid && in_ready));
        words_sent++;
        @(negedge i_clk);
    endtask

    // APB write: setup then access; the register latches on the access edge.
    // The bus then idles with psel low before the next transfer may start.
    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every predicted word, then let the block finish
    // any symbol that produces no result.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_config(int step, int shortest, int longest);
        drain_block();
        write_reg(REG_STEP, 16'(step));
        write_reg(REG_SHORTEST, 16'(shortest));
        write_reg(REG_LONGEST, 16'(longest));
        cur_step = step;
    endtask

    function automatic logic [15:0] nominal_period(t_code c);
        return 16'(int'(c) * int'(STEP_RESET));
    endfunction

    // A period that rounds to the given code under the current step,
    // anywhere inside its rounding bin; clamped to the field range.
    function automatic logic [15:0] period_for(t_code c);
        int p;
        if (c == CODE_NONE || cur_step == 0) return 16'($urandom_range(0, 65535));
        p = int'(c) * cur_step - cur_step / 2 + int'($urandom_range(0, cur_step - 1));
        if (p < 0) p = 0;
        if (p > 65535) p = 65535;
        return 16'(p);
    endfunction

    // Mostly well-formed frames with random bits, sprinkled with stray
    // periods, broken transitions and capture ends in odd places.
    task automatic send_frames(int n_words);
        int    goal;
        int    nbits;
        int    ending;
        logic  prev;
        logic  b;
        t_code code;
        goal = words_sent + n_words;
        while (words_sent < goal) begin
            if ($urandom_range(0, 9) < 2) begin
                send_word(16'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0);
            end else begin
                send_word(period_for(CODE_START), 1'b0);
                prev  = 1'b1;
                nbits = $urandom_range(0, 14);
                for (int i = 0; i < nbits; i++) begin
                    if ($urandom_range(0, 24) == 0) begin
                        send_word(period_for(t_code'($urandom_range(0, 5))), 1'b0);
                        break;
                    end
                    b = 1'($urandom_range(0, 1));
                    if (prev) code = b ? CODE_TWO : CODE_ONE;
                    else      code = b ? CODE_THREE : CODE_TWO;
                    prev = b;
                    send_word(period_for(code), $urandom_range(0, 39) == 0);
                end
                ending = $urandom_range(0, 9);
                if (ending < 6)
                    send_word(period_for(CODE_STOP), $urandom_range(0, 3) == 0);
                else if (ending < 8)
                    send_word(period_for(t_code'($urandom_range(0, 5))), 1'b1);
                // otherwise the next start cuts it
            end
        end
    endtask

    // Long legal frame so the bit count saturates.
    task automatic send_long_frame(int nbits);
        logic b;
        logic prev;
        prev = 1'b1;
        send_word(period_for(CODE_START), 1'b0);
        for (int i = 0; i < nbits; i++) begin
            b = 1'($urandom_range(0, 1));
            if (prev) send_word(period_for(b ? CODE_TWO : CODE_ONE), 1'b0);
            else      send_word(period_for(b ? CODE_THREE : CODE_TWO), 1'b0);
            prev = b;
        end
        send_word(period_for(CODE_STOP), 1'b0);
    endtask

    initial begin : stimulus
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed words under the reset settings
        send_word(16'd0, 1'b0);                         // far below window, no frame
        send_word(16'hFFFF, 1'b0);                      // far above window, no frame
        send_word(nominal_period(CODE_START), 1'b0);
        send_word(nominal_period(CODE_STOP), 1'b0);     // stop on an empty frame
        send_word(nominal_period(CODE_START), 1'b0);
        send_word(nominal_period(CODE_ONE), 1'b0);      // 1 -> 0
        send_word(nominal_period(CODE_THREE), 1'b0);    // 0 -> 1
        send_word(nominal_period(CODE_TWO), 1'b0);      // 1 -> 1
        send_word(nominal_period(CODE_ONE), 1'b0);      // 1 -> 0
        send_word(nominal_period(CODE_TWO), 1'b0);      // 0 -> 0
        send_word(nominal_period(CODE_START), 1'b0);    // restart cuts a full frame
        send_word(nominal_period(CODE_START), 1'b0);    // empty frame dropped quietly
        send_word(nominal_period(CODE_THREE), 1'b0);    // illegal after a 1
        send_word(nominal_period(CODE_START), 1'b0);
        send_word(nominal_period(CODE_TWO), 1'b0);
        send_word(nominal_period(CODE_ONE), 1'b0);
        send_word(nominal_period(CODE_ONE), 1'b0);      // illegal after a 0
        send_word(nominal_period(CODE_START), 1'b0);
        send_word(16'd1563, 1'b0);                      // lowest period still accepted
        send_word(16'd1562, 1'b0);                      // just under the window: abort
        send_word(nominal_period(CODE_START), 1'b0);
        send_word(16'd17187, 1'b0);                     // highest accepted, rounds to start
        send_word(nominal_period(CODE_TWO), 1'b1);      // bit then capture-end cut
        send_word(16'd17188, 1'b0);                     // just over the window
        send_word(nominal_period(CODE_START), 1'b1);    // start and capture end together
        send_word(nominal_period(CODE_TWO), 1'b1);      // capture end outside a frame

        // random part, reset settings; the receiver stalls hard at the start
        hold_off_req = 1'b1;
        send_frames(150);
        send_long_frame(260);

        load_config(1000, 1000, 5000);
        send_frames(80);
        load_config(1, 0, 65535);             // smallest step, widest window
        send_frames(80);
        load_config(13107, 0, 65535);         // code 5 lands on the top of the range
        send_frames(80);
        load_config(65535, 0, 65535);         // largest step: only code 1 possible
        send_frames(30);
        load_config(0, 3125, 15625);          // zero step: nothing decodes
        send_frames(30);
        load_config(16383, 65535, 0);         // inverted edges: empty window
        send_frames(30);

        // last part: both sides flat out
        load_config(2000, 1500, 10000);
        idle_on = 1'b0;
        send_frames(120);

        drain_block();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ppdbd_pkg.sv
hdl/ppdbd_queue.sv
hdl/ppdbd_front.sv
hdl/ppdbd_back.sv
hdl/pulse_period_differential_bit_decoder_unit.sv
hdl/ppdbd_checker.sv
tb/ppdbd_checker.sv
tb/tb_top.sv
